[hw/rtl/npc_pkg.sv]
// ----------------------------------------------------------------------------
// npc_pkg
// Shared constants, codes and types of the nearest-prototype classifier.
// ----------------------------------------------------------------------------
package npc_pkg;

    // Sizing
    localparam int MAX_CLUSTERS = 256;
    localparam int MAX_VECTOR   = 64;
    localparam int ELEMENT_BITS = 16;

    localparam int CLUSTER_AW  = (MAX_CLUSTERS > 1) ? $clog2(MAX_CLUSTERS) : 1;
    localparam int VEC_AW      = (MAX_VECTOR > 1) ? $clog2(MAX_VECTOR) : 1;
    localparam int PROTO_DEPTH = MAX_CLUSTERS * MAX_VECTOR;
    localparam int PROTO_AW    = (PROTO_DEPTH > 1) ? $clog2(PROTO_DEPTH) : 1;
    localparam int LEN_W       = $clog2(MAX_VECTOR + 1);

    localparam int SCORE_W = 48;
    localparam int BIAS_W  = 32;
    localparam logic [SCORE_W-1:0] SCORE_MAX = '1;

    // Item modes
    localparam logic [1:0] MODE_PROTO  = 2'd0;
    localparam logic [1:0] MODE_BIAS   = 2'd1;
    localparam logic [1:0] MODE_SAMPLE = 2'd2;

    // Configuration register indexes
    localparam logic [1:0] CFG_CLUSTER_COUNT = 2'd0;
    localparam logic [1:0] CFG_VECTOR_LENGTH = 2'd1;
    localparam logic [1:0] CFG_USE_PRIOR     = 2'd2;

    localparam logic [8:0]  CLUSTER_COUNT_RST = 9'd16;
    localparam logic [10:0] VECTOR_LENGTH_RST = 11'd64;

    typedef struct packed {
        logic [1:0]  mode;
        logic [7:0]  cluster_index;
        logic [9:0]  element_index;
        logic [15:0] element_value;
        logic [31:0] bias_value;
        logic        last_element;
    } in_item_t;

    typedef struct packed {
        logic [7:0]  best_cluster;
        logic [47:0] best_score;
    } result_t;

    // Controller to datapath commands
    typedef struct packed {
        logic                  proto_we;
        logic                  bias_we;
        logic                  capture;
        logic                  issue;
        logic                  issue_first;
        logic                  issue_final;
        logic [CLUSTER_AW-1:0] issue_idx;
        logic                  clear_valid;
    } ctl_t;

    // Datapath to controller status
    typedef struct packed {
        logic pass_done;
    } st_t;

endpackage

[hw/rtl/npc_ram.sv]
// ----------------------------------------------------------------------------
// npc_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module npc_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 256
) (
    input  logic                                     clk,
    input  logic                                     we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                         wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        rdata <= mem[raddr];
    end

endmodule

[hw/rtl/npc_ctrl.sv]
// ----------------------------------------------------------------------------
// npc_ctrl
// Controller: decodes accepted items, walks the clusters of one sample
// element through the datapath and raises the result strobe.
// ----------------------------------------------------------------------------
module npc_ctrl
    import npc_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    input  logic [1:0]            mode,
    input  logic                  last_element,
    input  logic [CLUSTER_AW-1:0] n_last,
    input  st_t                   st,
    output ctl_t                  ctl,
    output logic                  busy,
    output logic                  result_valid
);

    typedef enum logic [1:0] {
        IDLE,
        ISSUE,
        DRAIN
    } state_t;

    state_t                state_reg, state_next;
    logic [CLUSTER_AW-1:0] cnt_reg, cnt_next;
    logic                  last_reg, last_next;
    logic                  done_reg, done_next;
    logic                  accept;

    assign accept = start && (state_reg == IDLE);
    assign busy   = (state_reg != IDLE);
    assign result_valid = done_reg;

    // Commands
    always_comb
    begin
        ctl             = '0;
        ctl.proto_we    = accept && (mode == MODE_PROTO);
        ctl.bias_we     = accept && (mode == MODE_BIAS);
        ctl.capture     = accept && (mode == MODE_SAMPLE);
        ctl.issue       = (state_reg == ISSUE);
        ctl.issue_idx   = cnt_reg;
        ctl.issue_first = (cnt_reg == '0);
        ctl.issue_final = (cnt_reg == n_last);
        ctl.clear_valid = (state_reg == DRAIN) && st.pass_done && last_reg;
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        last_next  = last_reg;
        done_next  = 1'b0;
        case (state_reg)
            IDLE:
            begin
                if (accept && (mode == MODE_SAMPLE))
                begin
                    state_next = ISSUE;
                    cnt_next   = '0;
                    last_next  = last_element;
                end
            end
            ISSUE:
            begin
                if (cnt_reg == n_last)
                begin
                    state_next = DRAIN;
                end
                else
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            DRAIN:
            begin
                if (st.pass_done)
                begin
                    state_next = IDLE;
                    done_next  = last_reg;
                end
            end
            default:
            begin
                state_next = IDLE;
            end
        endcase
    end

    // State and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= IDLE;
            cnt_reg   <= '0;
            last_reg  <= 1'b0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            last_reg  <= last_next;
            done_reg  <= done_next;
        end
    end

endmodule

[hw/rtl/npc_datapath.sv]
// ----------------------------------------------------------------------------
// npc_datapath
// Prototype, bias and accumulator memories with a five-stage pipeline:
// read, difference, square, accumulate and bias add, then a running minimum.
// ----------------------------------------------------------------------------
module npc_datapath
    import npc_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  ctl_t             ctl,
    input  in_item_t         item,
    input  logic [LEN_W-1:0] len_eff,
    input  logic             use_prior,
    output st_t              st,
    output result_t          result
);

    localparam int SQ_W   = 2 * ELEMENT_BITS;
    localparam int SUM_W  = ((SQ_W > SCORE_W) ? SQ_W : SCORE_W) + 1;
    localparam int BSUM_W = SCORE_W + 1;
    localparam int CMP_W  = ((LEN_W > 10) ? LEN_W : 10) + 1;

    // Captured sample element
    logic [ELEMENT_BITS-1:0] smp_val_reg;
    logic [VEC_AW-1:0]       smp_ei_reg;
    logic                    smp_in_range_reg;
    logic                    in_range_now;

    // Memory ports
    logic                    proto_we;
    logic [PROTO_AW-1:0]     proto_waddr, proto_raddr;
    logic [ELEMENT_BITS-1:0] proto_rdata;
    logic                    bias_we;
    logic [BIAS_W-1:0]       bias_rdata;
    logic [SCORE_W-1:0]      acc_rdata;
    logic [SCORE_W-1:0]      acc_new;
    logic [MAX_CLUSTERS-1:0] acc_vld_reg;

    // Pipeline
    logic                    s1_vld_reg, s2_vld_reg, s3_vld_reg, s4_vld_reg, s5_vld_reg;
    logic [CLUSTER_AW-1:0]   s1_idx_reg, s2_idx_reg, s3_idx_reg, s4_idx_reg, s5_idx_reg;
    logic                    s1_first_reg, s2_first_reg, s3_first_reg, s4_first_reg;
    logic                    s5_first_reg;
    logic                    s1_final_reg, s2_final_reg, s3_final_reg, s4_final_reg;
    logic                    s5_final_reg;
    logic [ELEMENT_BITS-1:0] diff2_reg, diff1;
    logic [SCORE_W-1:0]      acc2_reg, acc3_reg, acc4_reg;
    logic [BIAS_W-1:0]       bias2_reg, bias3_reg, bias4_reg;
    logic [SQ_W-1:0]         sq3_reg;
    logic [SUM_W-1:0]        sum3;
    logic [BSUM_W-1:0]       bsum4;
    logic [SCORE_W-1:0]      score4, score5_reg;
    logic [CLUSTER_AW-1:0]   best_idx_reg;
    logic [SCORE_W-1:0]      best_score_reg;
    logic                    take5;

    // Load decode
    assign proto_we = ctl.proto_we && (item.cluster_index < MAX_CLUSTERS)
                      && (item.element_index < MAX_VECTOR);
    assign bias_we  = ctl.bias_we && (item.cluster_index < MAX_CLUSTERS);
    assign proto_waddr = PROTO_AW'(item.cluster_index) * PROTO_AW'(MAX_VECTOR)
                         + PROTO_AW'(item.element_index);
    assign proto_raddr = PROTO_AW'(ctl.issue_idx) * PROTO_AW'(MAX_VECTOR)
                         + PROTO_AW'(smp_ei_reg);

    assign in_range_now = CMP_W'(item.element_index) < CMP_W'(len_eff);

    // Sample capture
    always_ff @(posedge clk)
    begin
        if (ctl.capture)
        begin
            smp_val_reg      <= ELEMENT_BITS'(item.element_value);
            smp_ei_reg       <= in_range_now ? VEC_AW'(item.element_index) : '0;
            smp_in_range_reg <= in_range_now;
        end
    end

    npc_ram #(
        .WIDTH (ELEMENT_BITS),
        .DEPTH (PROTO_DEPTH)
    ) u_proto_ram (
        .clk   (clk),
        .we    (proto_we),
        .waddr (proto_waddr),
        .wdata (ELEMENT_BITS'(item.element_value)),
        .raddr (proto_raddr),
        .rdata (proto_rdata)
    );

    npc_ram #(
        .WIDTH (BIAS_W),
        .DEPTH (MAX_CLUSTERS)
    ) u_bias_ram (
        .clk   (clk),
        .we    (bias_we),
        .waddr (CLUSTER_AW'(item.cluster_index)),
        .wdata (item.bias_value),
        .raddr (ctl.issue_idx),
        .rdata (bias_rdata)
    );

    npc_ram #(
        .WIDTH (SCORE_W),
        .DEPTH (MAX_CLUSTERS)
    ) u_acc_ram (
        .clk   (clk),
        .we    (s3_vld_reg),
        .waddr (s3_idx_reg),
        .wdata (acc_new),
        .raddr (ctl.issue_idx),
        .rdata (acc_rdata)
    );

    // Accumulator valid bits: an entry not written since the last clear reads zero
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_vld_reg <= '0;
        end
        else if (ctl.clear_valid)
        begin
            acc_vld_reg <= '0;
        end
        else if (s3_vld_reg)
        begin
            acc_vld_reg[s3_idx_reg] <= 1'b1;
        end
    end

    // Stage arithmetic
    assign diff1 = (smp_val_reg >= proto_rdata) ? (smp_val_reg - proto_rdata)
                                                : (proto_rdata - smp_val_reg);
    assign sum3  = SUM_W'(acc3_reg) + SUM_W'(sq3_reg);
    assign acc_new = (sum3 > SUM_W'(SCORE_MAX)) ? SCORE_MAX : SCORE_W'(sum3);
    assign bsum4 = BSUM_W'(acc4_reg) + BSUM_W'(bias4_reg);
    assign score4 = !use_prior ? acc4_reg
                  : ((bsum4 > BSUM_W'(SCORE_MAX)) ? SCORE_MAX : SCORE_W'(bsum4));
    assign take5 = s5_first_reg || (score5_reg < best_score_reg);

    // Pipeline valids
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_vld_reg <= 1'b0;
            s2_vld_reg <= 1'b0;
            s3_vld_reg <= 1'b0;
            s4_vld_reg <= 1'b0;
            s5_vld_reg <= 1'b0;
        end
        else
        begin
            s1_vld_reg <= ctl.issue;
            s2_vld_reg <= s1_vld_reg;
            s3_vld_reg <= s2_vld_reg;
            s4_vld_reg <= s3_vld_reg;
            s5_vld_reg <= s4_vld_reg;
        end
    end

    // Pipeline payload
    always_ff @(posedge clk)
    begin
        s1_idx_reg   <= ctl.issue_idx;
        s1_first_reg <= ctl.issue_first;
        s1_final_reg <= ctl.issue_final;

        s2_idx_reg   <= s1_idx_reg;
        s2_first_reg <= s1_first_reg;
        s2_final_reg <= s1_final_reg;
        diff2_reg    <= diff1;
        acc2_reg     <= acc_vld_reg[s1_idx_reg] ? acc_rdata : '0;
        bias2_reg    <= bias_rdata;

        s3_idx_reg   <= s2_idx_reg;
        s3_first_reg <= s2_first_reg;
        s3_final_reg <= s2_final_reg;
        sq3_reg      <= smp_in_range_reg ? (SQ_W'(diff2_reg) * SQ_W'(diff2_reg)) : '0;
        acc3_reg     <= acc2_reg;
        bias3_reg    <= bias2_reg;

        s4_idx_reg   <= s3_idx_reg;
        s4_first_reg <= s3_first_reg;
        s4_final_reg <= s3_final_reg;
        acc4_reg     <= acc_new;
        bias4_reg    <= bias3_reg;

        s5_idx_reg   <= s4_idx_reg;
        s5_first_reg <= s4_first_reg;
        s5_final_reg <= s4_final_reg;
        score5_reg   <= score4;
    end

    // Running minimum, ties keep the lower index
    always_ff @(posedge clk)
    begin
        if (s5_vld_reg && take5)
        begin
            best_idx_reg   <= s5_idx_reg;
            best_score_reg <= score5_reg;
        end
    end

    assign st.pass_done        = s5_vld_reg && s5_final_reg;
    assign result.best_cluster = 8'(best_idx_reg);
    assign result.best_score   = best_score_reg;

endmodule

[hw/rtl/nearest_prototype_classifier.sv]
// Operation: a load (prototype or bias element) is written on acceptance; busy stays low.
// A sample element keeps busy high while its clusters pass through: one cluster
// enters the five-stage distance pipeline per cycle through the accumulator RAM.
// On the last element the result strobe rises as busy falls. Results cannot be stalled.
// Reset clears control state, the accumulators (via valid bits) and the registers
// to their defaults.
// ----------------------------------------------------------------------------
// nearest_prototype_classifier
// Nearest-prototype classifier on squared Euclidean distance with an optional
// per-cluster prior bias; top level with configuration registers.
// ----------------------------------------------------------------------------
module nearest_prototype_classifier
    import npc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  in_item_t    item,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [31:0] cfg_data,
    output logic        result_valid,
    output result_t     result
);

    logic [8:0]            cluster_count_reg;
    logic [10:0]           vector_length_reg;
    logic                  use_prior_reg;
    logic [CLUSTER_AW-1:0] n_last;
    logic [LEN_W-1:0]      len_eff;
    ctl_t                  ctl;
    st_t                   st;

    assign cfg_ready = 1'b1;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cluster_count_reg <= CLUSTER_COUNT_RST;
            vector_length_reg <= VECTOR_LENGTH_RST;
            use_prior_reg     <= 1'b0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_CLUSTER_COUNT: cluster_count_reg <= cfg_data[8:0];
                CFG_VECTOR_LENGTH: vector_length_reg <= cfg_data[10:0];
                CFG_USE_PRIOR:     use_prior_reg     <= cfg_data[0];
                default:           ;
            endcase
        end
    end

    // Effective cluster count and vector length
    always_comb
    begin
        if (cluster_count_reg == '0)
        begin
            n_last = '0;
        end
        else if (32'(cluster_count_reg) > MAX_CLUSTERS)
        begin
            n_last = CLUSTER_AW'(MAX_CLUSTERS - 1);
        end
        else
        begin
            n_last = CLUSTER_AW'(cluster_count_reg - 9'd1);
        end

        if (vector_length_reg == '0)
        begin
            len_eff = LEN_W'(1);
        end
        else if (32'(vector_length_reg) > MAX_VECTOR)
        begin
            len_eff = LEN_W'(MAX_VECTOR);
        end
        else
        begin
            len_eff = LEN_W'(vector_length_reg);
        end
    end

    npc_ctrl u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .mode         (item.mode),
        .last_element (item.last_element),
        .n_last       (n_last),
        .st           (st),
        .ctl          (ctl),
        .busy         (busy),
        .result_valid (result_valid)
    );

    npc_datapath u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctl       (ctl),
        .item      (item),
        .len_eff   (len_eff),
        .use_prior (use_prior_reg),
        .st        (st),
        .result    (result)
    );

`ifndef ASSERT_OFF
    // A result is a single-cycle strobe
    a_strobe_single: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |=> !result_valid)
        else $error("result strobe held longer than one cycle");

    // A sample element transfer makes the block busy
    a_sample_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && (item.mode == MODE_SAMPLE)) |=> busy)
        else $error("sample element accepted without going busy");

    // The pipeline only finishes a pass while busy
    a_pass_busy: assert property (@(posedge clk) disable iff (!rst_n)
        st.pass_done |-> busy)
        else $error("distance pass finished while idle");
`endif

endmodule
